FILE: rtl/bb3_pkg.sv
// Shared constants and controller/datapath handshake types for the 3x3 box blur.
// No dependencies; used by the configuration interface, the controller, the datapath and the top level.
`timescale 1ns / 1ps
package bb3_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int HEIGHT_LIMIT  = 1024;
  localparam int CFG_W         = 11;
  localparam int CFG_IDX_W     = 2;
  localparam int ROW_W         = 11;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;

  // Rounding divider: numerator 2*sum+count, denominator 2*count
  localparam int SUM_W     = 12;
  localparam int NUM_W     = 13;
  localparam int DEN_W     = 5;
  localparam int DIV_STEPS = NUM_W;
  localparam int STEP_W    = 4;

  typedef struct packed {
    logic take_in;
    logic rd;
    logic win;
    logic sum;
    logic div_step;
    logic push;
  } bb3_cmd_t;

  typedef struct packed {
    logic ignore;
    logic has_out;
    logic out_free;
  } bb3_sts_t;

endpackage

FILE: rtl/bb3_in_if.sv
// Input pixel channel: valid/ready with action flag and RGB payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface bb3_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, action, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, action, in_red, in_green, in_blue, output ready);
endinterface

FILE: rtl/bb3_out_if.sv
// Result channel: valid/ready with blurred RGB and end-of-frame flag.
// Depends on nothing.
`timescale 1ns / 1ps
interface bb3_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_done;
  modport source (output valid, out_red, out_green, out_blue, frame_done, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_done, output ready);
endinterface

FILE: rtl/bb3_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Uses bb3_pkg for field widths.
`timescale 1ns / 1ps
interface bb3_cfg_if import bb3_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/bb3_ctrl.sv
// Sequencer for the box blur: steps each non-ignored transfer through read and
// window, then, if it yields a pixel, sum, divide and hand-off. Uses bb3_pkg command/status types.
`timescale 1ns / 1ps
module bb3_ctrl
  import bb3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bb3_sts_t sts,
  output bb3_cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_WIN, S_SUM, S_DIV, S_PUSH} state_t;

  state_t            state_r;
  logic [STEP_W-1:0] step_r;

  assign in_ready = (state_r == S_IDLE);

  // Decode commands from state
  always_comb begin
    cmd          = '0;
    cmd.take_in  = (state_r == S_IDLE) && in_valid && !sts.ignore;
    cmd.rd       = (state_r == S_RD);
    cmd.win      = (state_r == S_WIN);
    cmd.sum      = (state_r == S_SUM);
    cmd.div_step = (state_r == S_DIV);
    cmd.push     = (state_r == S_PUSH) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !sts.ignore) state_r <= S_RD;
        end
        S_RD:  state_r <= S_WIN;
        S_WIN: state_r <= sts.has_out ? S_SUM : S_IDLE;
        S_SUM: begin
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(DIV_STEPS - 1)) state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (sts.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/bb3_dp.sv
// Datapath: line stores, 3x3 window, raster counters, masked sums, rounding
// divider and output register. Uses bb3_pkg; driven by bb3_ctrl.
`timescale 1ns / 1ps
module bb3_dp
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bb3_cmd_t             cmd,
  output bb3_sts_t             sts,
  input  logic                 in_action,
  input  logic [23:0]          in_pix,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [23:0]          out_pix,
  output logic                 out_done
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [CFG_W-1:0] fw_r, fh_r;
  logic [WW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [CW-1:0]    col_r;
  logic [ROW_W-1:0] row_r;
  logic             inputs_done;

  logic [23:0] upper_mem [MAX_WIDTH];
  logic [23:0] middle_mem [MAX_WIDTH];
  logic [23:0] u_q, m_q, px_r;
  logic [23:0] win_r [9];

  logic [WW-1:0]    c_ext, oj;
  logic [ROW_W-1:0] oi;
  logic             c_pos, has_out, done;
  logic [2:0]       rowok, colok;
  logic [2:0]       rowok_r, colok_r;
  logic             done_r;

  logic [SUM_W-1:0] sum [3];
  logic [1:0]       nrows, ncols;
  logic [3:0]       count;

  logic [NUM_W-1:0] num_r [3];
  logic [DEN_W-1:0] rem_r [3];
  logic [DEN_W-1:0] den_r;
  logic             out_valid_r;
  logic [23:0]      out_pix_r;
  logic             out_done_r;

  // Effective frame size after clamping
  always_comb begin
    if (fw_r == '0) w_eff = WW'(1);
    else if (32'(fw_r) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(fw_r);
    if (fh_r == '0) h_eff = ROW_W'(1);
    else if (32'(fh_r) > 32'(HEIGHT_LIMIT)) h_eff = ROW_W'(HEIGHT_LIMIT);
    else h_eff = fh_r;
  end

  assign inputs_done = (row_r >= h_eff);

  // Window centre and edge masks for the current position
  always_comb begin
    c_ext   = WW'(col_r);
    c_pos   = (col_r != '0);
    has_out = c_pos ? (row_r >= ROW_W'(1)) : (row_r >= ROW_W'(2));
    oi      = c_pos ? row_r - ROW_W'(1) : row_r - ROW_W'(2);
    oj      = c_pos ? c_ext - WW'(1) : w_eff - WW'(1);
    rowok   = {(oi + ROW_W'(1) < h_eff), 1'b1, (oi >= ROW_W'(1))};
    colok   = {(oj + WW'(1) < w_eff), 1'b1, (oj >= WW'(1))};
    done    = (oi == h_eff - ROW_W'(1)) && (oj == w_eff - WW'(1));
  end

  assign sts.ignore   = !inputs_done && in_action;
  assign sts.has_out  = has_out;
  assign sts.out_free = !out_valid_r || out_ready;

  // Configuration and raster counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= RESET_WIDTH;
      fh_r  <= RESET_HEIGHT;
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          fw_r  <= cfg_data;
          col_r <= '0;
          row_r <= '0;
        end
        REG_FRAME_HEIGHT: begin
          fh_r  <= cfg_data;
          col_r <= '0;
          row_r <= '0;
        end
        default: ;
      endcase
    end else if (cmd.win) begin
      if (has_out && done) begin
        col_r <= '0;
        row_r <= '0;
      end else if (c_ext + WW'(1) >= w_eff) begin
        col_r <= '0;
        row_r <= row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // Input capture; pixels past frame end count as black drain
  always_ff @(posedge clk) begin
    if (cmd.take_in) px_r <= inputs_done ? 24'd0 : in_pix;
  end

  // Line stores: read in RD, write back in WIN
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      u_q <= upper_mem[col_r];
      m_q <= middle_mem[col_r];
    end
    if (cmd.win) begin
      upper_mem[col_r]  <= m_q;
      middle_mem[col_r] <= px_r;
    end
  end

  // 3x3 window shift and edge flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) win_r[k] <= '0;
    end else if (cmd.win) begin
      for (int dr = 0; dr < 3; dr++) begin
        win_r[dr*3]   <= win_r[dr*3+1];
        win_r[dr*3+1] <= win_r[dr*3+2];
      end
      win_r[2] <= u_q;
      win_r[5] <= m_q;
      win_r[8] <= px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win) begin
      rowok_r <= rowok;
      colok_r <= colok;
      done_r  <= done;
    end
  end

  // Masked channel sums and pixel count
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int k = 0; k < 9; k++) begin
        if (rowok_r[k/3] && colok_r[k%3])
          sum[ch] = sum[ch] + SUM_W'(win_r[k][(2-ch)*8 +: 8]);
      end
    end
    nrows = 2'(rowok_r[0]) + 2'(rowok_r[1]) + 2'(rowok_r[2]);
    ncols = 2'(colok_r[0]) + 2'(colok_r[1]) + 2'(colok_r[2]);
    count = 4'(nrows) * 4'(ncols);
  end

  // Restoring divider, one quotient bit per step, all channels together
  always_ff @(posedge clk) begin
    logic [DEN_W:0] t;
    if (cmd.sum) begin
      for (int ch = 0; ch < 3; ch++) begin
        num_r[ch] <= {sum[ch], 1'b0} + NUM_W'(count);
        rem_r[ch] <= '0;
      end
      den_r <= {count, 1'b0};
    end else if (cmd.div_step) begin
      for (int ch = 0; ch < 3; ch++) begin
        t = {rem_r[ch], num_r[ch][NUM_W-1]};
        if (t >= {1'b0, den_r}) begin
          rem_r[ch] <= DEN_W'(t - {1'b0, den_r});
          num_r[ch] <= {num_r[ch][NUM_W-2:0], 1'b1};
        end else begin
          rem_r[ch] <= DEN_W'(t);
          num_r[ch] <= {num_r[ch][NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_pix_r  <= {num_r[0][7:0], num_r[1][7:0], num_r[2][7:0]};
      out_done_r <= done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;
  assign out_done  = out_done_r;

endmodule

FILE: rtl/box_blur_3x3_edge_aware.sv
// 3x3 box blur over a raster RGB pixel stream, counting only in-frame
// neighbours and rounding each channel mean half up. Each transfer goes through
// the accept step, one line-store read and one window update (an ignored drain
// stops at accept); one that yields a pixel then takes one summing step, 13
// steps of a restoring divider over all channels together and the hand-off to
// the output register, which waits out any output stall. Output lags input by
// one row plus one pixel; after the frame, drain transfers (or extra pixels)
// flush the rest, and frame_done marks the last one. Write configuration only while
// idle; a width or height register write restarts the frame. Line stores start undefined.
`timescale 1ns / 1ps
module box_blur_3x3_edge_aware
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  bb3_in_if.sink     in_px,
  bb3_out_if.source  out_px,
  bb3_cfg_if.sink    cfg_wr
);

  bb3_cmd_t    cmd;
  bb3_sts_t    sts;
  logic [23:0] out_pix;

  assign cfg_wr.ready = 1'b1;

  bb3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_px.valid),
    .in_ready (in_px.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bb3_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_action (in_px.action),
    .in_pix    ({in_px.in_red, in_px.in_green, in_px.in_blue}),
    .cfg_we    (cfg_wr.valid),
    .cfg_index (cfg_wr.index),
    .cfg_data  (cfg_wr.data),
    .out_valid (out_px.valid),
    .out_ready (out_px.ready),
    .out_pix   (out_pix),
    .out_done  (out_px.frame_done)
  );

  assign out_px.out_red   = out_pix[23:16];
  assign out_px.out_green = out_pix[15:8];
  assign out_px.out_blue  = out_pix[7:0];

endmodule

FILE: tb/box_blur_checker.sv
// Scoreboard for the 3x3 box blur: watches the pixel, result and register channels,
// predicts every blurred pixel and compares it. Uses bb3_pkg and the three RTL interfaces.
`timescale 1ns / 1ps
module box_blur_checker
  import bb3_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  bb3_in_if    in_px,
  bb3_out_if   out_px,
  bb3_cfg_if   cfg_wr,
  output int   pending,
  output int   fail_count
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_done;
  } blur_px_t;

  blur_px_t        blurred_q[$];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [23:0]      upper_mem [MAX_WIDTH_DEF];
  logic [23:0]      middle_mem[MAX_WIDTH_DEF];
  logic [23:0]      win[9];
  int unsigned      in_col;
  int unsigned      in_row;

  initial begin
    fail_count = 0;
    pending    = 0;
    for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
      upper_mem[i]  = '0;
      middle_mem[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
  end

  // Process one tick: advance the raster position and queue the blurred pixel it yields, if any
  function automatic void blur_tick(input logic act, input logic [23:0] px_in);
    int unsigned w, h, c, r, oi, oj, rows, cols, cnt;
    int unsigned sum[3];
    logic [23:0] px, u, m, p;
    bit row_ok, col_ok, done;
    blur_px_t res;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
    c = in_col % MAX_WIDTH_DEF;
    r = in_row;
    // drain tick while pixels are still due: ignored
    if (r < h && act) return;
    px = (r >= h) ? 24'd0 : px_in;
    u = upper_mem[c];
    m = middle_mem[c];
    upper_mem[c]  = m;
    middle_mem[c] = px;
    for (int dr = 0; dr < 3; dr++) begin
      win[dr*3]   = win[dr*3+1];
      win[dr*3+1] = win[dr*3+2];
    end
    win[2] = u;
    win[5] = m;
    win[8] = px;
    if (c + 1 >= w) begin
      in_col = 0;
      in_row = r + 1;
    end else begin
      in_col = c + 1;
    end
    // centre of the window, one row and one pixel behind
    if (c >= 1) begin
      if (r < 1) return;
      oi = r - 1;
      oj = c - 1;
    end else begin
      if (r < 2) return;
      oi = r - 2;
      oj = w - 1;
    end
    rows = 0;
    cols = 0;
    sum[0] = 0; sum[1] = 0; sum[2] = 0;
    for (int dr = 0; dr < 3; dr++) begin
      row_ok = (dr == 0) ? (oi >= 1) : ((dr == 2) ? (oi + 1 < h) : 1'b1);
      if (row_ok) begin
        rows++;
        for (int dc = 0; dc < 3; dc++) begin
          col_ok = (dc == 0) ? (oj >= 1) : ((dc == 2) ? (oj + 1 < w) : 1'b1);
          if (col_ok) begin
            p = win[dr*3+dc];
            sum[0] += p[23:16];
            sum[1] += p[15:8];
            sum[2] += p[7:0];
          end
        end
      end
    end
    for (int dc = 0; dc < 3; dc++) begin
      col_ok = (dc == 0) ? (oj >= 1) : ((dc == 2) ? (oj + 1 < w) : 1'b1);
      if (col_ok) cols++;
    end
    cnt  = rows * cols;
    done = (oi == h - 1) && (oj == w - 1);
    // mean rounded half up
    res.red        = 8'((2 * sum[0] + cnt) / (2 * cnt));
    res.green      = 8'((2 * sum[1] + cnt) / (2 * cnt));
    res.blue       = 8'((2 * sum[2] + cnt) / (2 * cnt));
    res.frame_done = done;
    blurred_q.push_back(res);
    if (done) begin
      in_col = 0;
      in_row = 0;
    end
  endfunction

  always @(posedge clk) begin
    blur_px_t exp_px;
    if (!rst_n) begin
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      in_col     = 0;
      in_row     = 0;
      blurred_q.delete();
    end else begin
      // register write restarts the frame; unused indexes do nothing
      if (cfg_wr.valid && cfg_wr.ready) begin
        case (cfg_wr.index)
          REG_FRAME_WIDTH: begin
            width_reg = cfg_wr.data;
            in_col = 0;
            in_row = 0;
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_wr.data;
            in_col = 0;
            in_row = 0;
          end
          default: ;
        endcase
      end
      if (in_px.valid && in_px.ready)
        blur_tick(in_px.action, {in_px.in_red, in_px.in_green, in_px.in_blue});
      // compare result transfer with the oldest expected pixel
      if (out_px.valid && out_px.ready) begin
        if (blurred_q.size() == 0) begin
          $error("unexpected result transfer: red %0d green %0d blue %0d frame_done %0b",
                 out_px.out_red, out_px.out_green, out_px.out_blue, out_px.frame_done);
          fail_count++;
        end else begin
          exp_px = blurred_q.pop_front();
          if (out_px.out_red !== exp_px.red) begin
            $error("out_red mismatch: expected %0d, got %0d", exp_px.red, out_px.out_red);
            fail_count++;
          end
          if (out_px.out_green !== exp_px.green) begin
            $error("out_green mismatch: expected %0d, got %0d", exp_px.green, out_px.out_green);
            fail_count++;
          end
          if (out_px.out_blue !== exp_px.blue) begin
            $error("out_blue mismatch: expected %0d, got %0d", exp_px.blue, out_px.out_blue);
            fail_count++;
          end
          if (out_px.frame_done !== exp_px.frame_done) begin
            $error("frame_done mismatch: expected %0b, got %0b",
                   exp_px.frame_done, out_px.frame_done);
            fail_count++;
          end
        end
      end
    end
    pending = blurred_q.size();
  end

endmodule

FILE: tb/tb_box_blur_3x3_edge_aware.sv
// Top of the box blur testbench: clock, reset, pixel and register stimulus, result sink.
// Depends on bb3_pkg, the RTL interfaces, box_blur_3x3_edge_aware and box_blur_checker.
`timescale 1ns / 1ps
module tb_box_blur_3x3_edge_aware;
  import bb3_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;

  logic clk;
  logic rst_n;
  int   pending;
  int   fail_count;
  bit   calm;
  bit   hold_req;
  int   items_sent;
  int   cur_wreg;
  int   cur_hreg;

  bb3_in_if  in_px();
  bb3_out_if out_px();
  bb3_cfg_if cfg_wr();

  box_blur_3x3_edge_aware i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (in_px),
    .out_px (out_px),
    .cfg_wr (cfg_wr)
  );

  box_blur_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_px      (in_px),
    .out_px     (out_px),
    .cfg_wr     (cfg_wr),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Result sink: random stall after each transfer, plus one long hold-off on request
  initial begin
    int gap;
    out_px.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_px.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_px.ready <= 1'b1;
      end else if (rst_n && out_px.valid && out_px.ready) begin
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
          out_px.ready <= 1'b0;
          repeat (gap) @(posedge clk);
          out_px.ready <= 1'b1;
        end
      end
    end
  end

  // One pixel-channel transfer; valid stays high into the next call when there is no gap
  task automatic send_tick(input logic act, input logic [23:0] px);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_px.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_px.valid    <= 1'b1;
    in_px.action   <= act;
    in_px.in_red   <= px[23:16];
    in_px.in_green <= px[15:8];
    in_px.in_blue  <= px[7:0];
    do @(posedge clk); while (!in_px.ready);
    items_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= val;
    do @(posedge clk); while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
  endtask

  // Wait until every expected pixel is out, then let ignored ticks finish
  task automatic settle();
    in_px.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [23:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // Whole frame: pixels with stray drain ticks, then the flushing ticks.
  // Without a register write the frame keeps the size last written.
  task automatic run_frame(input bit write_cfg, input int wreg, input int hreg,
                           input bit noise);
    int w, h;
    if (write_cfg) begin
      cur_wreg = wreg;
      cur_hreg = hreg;
    end
    w = (cur_wreg == 0) ? 1 : ((cur_wreg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cur_wreg);
    h = (cur_hreg == 0) ? 1 : ((cur_hreg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : cur_hreg);
    if (write_cfg) begin
      settle();
      cfg_write(REG_FRAME_WIDTH, CFG_W'(wreg));
      cfg_write(REG_FRAME_HEIGHT, CFG_W'(hreg));
    end
    for (int i = 0; i < w * h; i++) begin
      if (noise && $urandom_range(0, 15) == 0) send_tick(1'b1, pick_pixel());
      send_tick(1'b0, pick_pixel());
    end
    // pixels after frame end act as drain ticks
    for (int i = 0; i <= w; i++) send_tick(noise ? 1'($urandom) : 1'b1, pick_pixel());
  endtask

  initial begin
    in_px.valid    = 1'b0;
    in_px.action   = 1'b0;
    in_px.in_red   = '0;
    in_px.in_green = '0;
    in_px.in_blue  = '0;
    cfg_wr.valid   = 1'b0;
    cfg_wr.index   = '0;
    cfg_wr.data    = '0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    items_sent     = 0;
    cur_wreg       = int'(RESET_WIDTH);
    cur_hreg       = int'(RESET_HEIGHT);
    rst_n          = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: tiny frames, out-of-range registers, spare indexes
    run_frame(1'b1, 1, 1, 1'b0);
    run_frame(1'b1, 0, 0, 1'b1);
    run_frame(1'b1, 3, 1, 1'b1);
    run_frame(1'b1, 1, 3, 1'b1);
    run_frame(1'b1, 2, 2, 1'b1);
    run_frame(1'b1, 3, 3, 1'b1);
    settle();
    cfg_write(REG_SPARE_LO, '1);
    cfg_write(REG_SPARE_HI, '0);
    run_frame(1'b0, 3, 3, 1'b1);
    run_frame(1'b1, 1, 2047, 1'b1);

    // Long output hold-off while pixels keep coming
    hold_req = 1'b1;
    run_frame(1'b1, 9, 6, 1'b0);

    // Random frames, mostly small, back to back or reconfigured
    while (items_sent < 1600) begin
      calm = ($urandom_range(0, 5) == 0);
      run_frame($urandom_range(0, 2) != 0, $urandom_range(1, 12), $urandom_range(1, 10),
                $urandom_range(0, 3) != 0);
    end
    calm = 1'b0;

    settle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bb3_pkg.sv
rtl/bb3_in_if.sv
rtl/bb3_out_if.sv
rtl/bb3_cfg_if.sv
rtl/bb3_ctrl.sv
rtl/bb3_dp.sv
rtl/box_blur_3x3_edge_aware.sv
tb/box_blur_checker.sv
tb/tb_box_blur_3x3_edge_aware.sv
